>>> sv/llf_pkg.sv
`default_nettype none

package llf_pkg;

  // Default pool size and stored value width.
  localparam int NODES_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths on the streaming ports.
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 4;
  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = VALUE_W + 2 * COUNT_W;

  // Request kinds carried on the input tuser.
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  // Result status carried on the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic issue;   // request accepted: latch it and start the memory reads
    logic commit;  // read data is valid: update state and load the result
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/llf_ram.sv
`default_nettype none

module llf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/llf_ctrl.sv
`default_nettype none

module llf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output llf_pkg::cmd_t      cmd_o
);

  import llf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   issue, commit;

  // A request is taken only while no other one is in flight.
  assign in_ready_o = (state_q == S_IDLE);
  assign issue      = in_valid_i && in_ready_o;
  // The result is committed once the output register is free or being emptied.
  assign commit     = (state_q == S_EXEC) && (!out_vld_q || out_ready_i);

  assign cmd_o.issue  = issue;
  assign cmd_o.commit = commit;
  assign out_valid_o  = out_vld_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (issue) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_vld_d = out_vld_q;
    if (commit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  a_issue_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> (state_q == S_EXEC))
    else $error("accepted request did not enter execution");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EXEC) && !commit) |=> (state_q == S_EXEC))
    else $error("stalled request left execution");

  a_commit_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_vld_q)
    else $error("committed result not presented");

endmodule

`default_nettype wire

>>> sv/llf_dp.sv
`default_nettype none

module llf_dp #(
  parameter int NODES      = llf_pkg::NODES_DEF,
  parameter int VALUE_BITS = llf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire llf_pkg::cmd_t               cmd_i,
  input  wire logic                        op_i,
  input  wire logic [llf_pkg::VALUE_W-1:0] value_i,
  output logic [llf_pkg::STATUS_W-1:0]     status_o,
  output logic [llf_pkg::VALUE_W-1:0]      value_out_o,
  output logic [llf_pkg::COUNT_W-1:0]      queued_o,
  output logic [llf_pkg::COUNT_W-1:0]      free_length_o
);

  import llf_pkg::*;

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  // List pointers and counts.
  logic [IW-1:0] sent_q, sent_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [IW-1:0] ftop_q, ftop_d;
  logic [IW-1:0] hnext_q, hnext_d;  // copy of the link out of the sentinel
  logic [CW-1:0] fcnt_q, fcnt_d;
  logic [CW-1:0] fresh_q, fresh_d;
  logic [CW-1:0] qcnt_q, qcnt_d;

  // Latched request.
  logic                  op_q;
  logic [VALUE_BITS-1:0] val_q;

  // Memory ports.
  logic                  nx_we;
  logic [IW-1:0]         nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic                  vl_we, vl_re;
  logic [IW-1:0]         vl_waddr;
  logic [VALUE_BITS-1:0] vl_rdata;

  logic          have_free, have_fresh;
  logic [IW-1:0] slot;
  status_e       status_d;
  logic [VALUE_W-1:0] vout_d;

  llf_ram #(.WIDTH(IW), .DEPTH(NODES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (nx_raddr),
    .rdata_o (nx_rdata)
  );

  llf_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODES)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vl_we),
    .waddr_i (vl_waddr),
    .wdata_i (val_q),
    .re_i    (vl_re),
    .raddr_i (hnext_q),
    .rdata_o (vl_rdata)
  );

  // Reads at accept: a dequeue fetches the first value and the link after it,
  // an enqueue fetches the link below the free-list top.
  assign nx_raddr = (op_i == OP_DEQ) ? hnext_q : ftop_q;
  assign vl_re    = cmd_i.issue && (op_i == OP_DEQ);

  assign have_free  = (fcnt_q != '0);
  assign have_fresh = (fresh_q < CW'(NODES));
  assign slot       = have_free ? ftop_q : fresh_q[IW-1:0];

  // State update at commit.
  always_comb begin
    sent_d   = sent_q;
    tail_d   = tail_q;
    ftop_d   = ftop_q;
    hnext_d  = hnext_q;
    fcnt_d   = fcnt_q;
    fresh_d  = fresh_q;
    qcnt_d   = qcnt_q;
    nx_we    = 1'b0;
    nx_waddr = tail_q;
    nx_wdata = slot;
    vl_we    = 1'b0;
    vl_waddr = slot;
    status_d = ST_OK;
    vout_d   = '0;
    if (op_q == OP_ENQ) begin
      if (have_free || have_fresh) begin
        vl_we  = cmd_i.commit;
        nx_we  = cmd_i.commit;
        tail_d = slot;
        qcnt_d = qcnt_q + CW'(1);
        if (qcnt_q == '0) begin
          hnext_d = slot;
        end
        if (have_free) begin
          ftop_d = nx_rdata;
          fcnt_d = fcnt_q - CW'(1);
        end else begin
          fresh_d = fresh_q + CW'(1);
        end
      end else begin
        status_d = ST_FULL;
      end
    end else begin
      if (qcnt_q == '0) begin
        status_d = ST_EMPTY;
      end else begin
        // Old sentinel goes on the free list, first node becomes sentinel.
        vout_d   = VALUE_W'(vl_rdata);
        sent_d   = hnext_q;
        hnext_d  = nx_rdata;
        nx_we    = cmd_i.commit;
        nx_waddr = sent_q;
        nx_wdata = ftop_q;
        ftop_d   = sent_q;
        fcnt_d   = fcnt_q + CW'(1);
        qcnt_d   = qcnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= '0;
      tail_q  <= '0;
      ftop_q  <= '0;
      hnext_q <= '0;
      fcnt_q  <= '0;
      fresh_q <= CW'(1);
      qcnt_q  <= '0;
    end else if (cmd_i.commit) begin
      sent_q  <= sent_d;
      tail_q  <= tail_d;
      ftop_q  <= ftop_d;
      hnext_q <= hnext_d;
      fcnt_q  <= fcnt_d;
      fresh_q <= fresh_d;
      qcnt_q  <= qcnt_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      op_q  <= op_i;
      val_q <= VALUE_BITS'(value_i);
    end
    if (cmd_i.commit) begin
      status_o      <= status_d;
      value_out_o   <= vout_d;
      queued_o      <= COUNT_W'(qcnt_d);
      free_length_o <= COUNT_W'(fcnt_d);
    end
  end

  // Every used node is queued, free, or the sentinel.
  a_node_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, fresh_q} == ({1'b0, qcnt_q} + {1'b0, fcnt_q} + (CW + 1)'(1))))
    else $error("node accounting broken");

  a_empty_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qcnt_q == '0) |-> (tail_q == sent_q))
    else $error("empty queue with tail away from sentinel");

  a_deq_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (op_q == OP_DEQ) && (qcnt_q != '0)) |=>
      (sent_q == $past(hnext_q)))
    else $error("dequeue did not advance the sentinel");

endmodule

`default_nettype wire

>>> sv/linked_list_fifo_with_free_list_top.sv
`default_nettype none

// Linked-list FIFO in a pool of NODES nodes with a sentinel and a free list.
// Each request (tuser 0 = enqueue tdata, 1 = dequeue) gives one result: status
// on tuser (0 ok, 1 dequeue on empty, 2 enqueue with pool full), and on tdata
// the dequeued value (zero otherwise) and the low four bits of the queued and
// free-list counts after the request. Node memory is read at the accept edge
// and the links and indices are written back at the commit edge, once read
// data is ready; a result not yet taken at the output holds back that commit.
// No clearing pass follows reset.
module linked_list_fifo_with_free_list_top #(
  parameter int NODES      = llf_pkg::NODES_DEF,
  parameter int VALUE_BITS = llf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [llf_pkg::VALUE_W-1:0]    s_axis_tdata,  // value
  input  wire logic                           s_axis_tuser,  // operation
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [llf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // value_out, queued, free_length
  output logic [llf_pkg::STATUS_W-1:0]        m_axis_tuser   // status
);

  import llf_pkg::*;

  cmd_t cmd;

  llf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  llf_dp #(
    .NODES      (NODES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (s_axis_tuser),
    .value_i       (s_axis_tdata),
    .status_o      (m_axis_tuser),
    .value_out_o   (m_axis_tdata[VALUE_W-1:0]),
    .queued_o      (m_axis_tdata[VALUE_W+COUNT_W-1:VALUE_W]),
    .free_length_o (m_axis_tdata[OUT_DATA_W-1:VALUE_W+COUNT_W])
  );

endmodule

`default_nettype wire

>>> test/tb_linked_list_fifo_with_free_list_top.sv
`default_nettype none

module tb_linked_list_fifo_with_free_list_top;
  import llf_pkg::*;

  localparam int POOL         = NODES_DEF;
  localparam int IDX_W        = $clog2(POOL);
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_REQS  = 1250;
  localparam int SETTLE       = 20;

  // One request waiting to be driven.
  typedef struct {
    op_e                op;
    logic [VALUE_W-1:0] value;
    int                 gap;
    bit                 drain;
  } llf_req_t;

  // One result, field by field.
  typedef struct {
    status_e            status;
    logic [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0] queued;
    logic [COUNT_W-1:0] free_len;
  } llf_res_t;

  // Operation mixes of the random phases.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  wire logic             s_axis_tready;
  logic [VALUE_W-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_ENQ;
  wire logic             m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire logic [OUT_DATA_W-1:0] m_axis_tdata;  // value_out, queued, free_length
  wire logic [STATUS_W-1:0]   m_axis_tuser;  // status

  llf_req_t pending_reqs[$];
  llf_res_t expected_results[$];
  llf_req_t cur_req;
  bit       req_loaded = 1'b0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       n_pred = 0;
  int       n_done = 0;
  int       n_total = 0;
  int       err_count = 0;
  int       cycle_count = 0;

  // Shadow copy of the list state.
  logic [VALUE_W-1:0] node_val[POOL];
  logic [IDX_W-1:0]   node_link[POOL];
  logic [IDX_W-1:0]   head_idx = '0;
  logic [IDX_W-1:0]   tail_idx = '0;
  logic [IDX_W-1:0]   stack_top = '0;
  logic [IDX_W:0]     stack_cnt = '0;
  logic [IDX_W:0]     unused_idx = (IDX_W + 1)'(1);
  logic [IDX_W:0]     value_cnt = '0;

  linked_list_fifo_with_free_list_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Applies one request to the shadow list and returns the result it yields.
  function automatic llf_res_t apply_list_request(op_e op, logic [VALUE_W-1:0] value);
    llf_res_t         res;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] old_head;
    logic [IDX_W-1:0] first;
    res.status    = ST_OK;
    res.value_out = '0;
    slot          = '0;
    if (op == OP_ENQ) begin
      // Recycled nodes go first, then never-used ones.
      if (stack_cnt != '0) begin
        slot      = stack_top;
        stack_top = node_link[slot];
        stack_cnt = stack_cnt - 1'b1;
      end else if (unused_idx < (IDX_W + 1)'(POOL)) begin
        slot       = unused_idx[IDX_W-1:0];
        unused_idx = unused_idx + 1'b1;
      end else begin
        res.status = ST_FULL;
      end
      if (res.status == ST_OK) begin
        node_val[slot]      = value;
        node_link[slot]     = '0;
        node_link[tail_idx] = slot;
        tail_idx            = slot;
        value_cnt           = value_cnt + 1'b1;
      end
    end else if (value_cnt == '0) begin
      res.status = ST_EMPTY;
    end else begin
      // The first value node becomes the sentinel; the old one is recycled.
      old_head      = head_idx;
      first         = node_link[old_head];
      res.value_out = node_val[first];
      head_idx      = first;
      if (tail_idx == old_head) tail_idx = first;
      node_link[old_head] = stack_top;
      stack_top           = old_head;
      stack_cnt           = stack_cnt + 1'b1;
      value_cnt           = value_cnt - 1'b1;
    end
    res.queued   = value_cnt[COUNT_W-1:0];
    res.free_len = stack_cnt[COUNT_W-1:0];
    return res;
  endfunction

  task automatic add_req(op_e op, logic [VALUE_W-1:0] value, int gap, bit drain);
    llf_req_t req;
    req.op    = op;
    req.value = value;
    req.gap   = gap;
    req.drain = drain;
    pending_reqs.push_back(req);
  endtask

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle count and timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Request driver: waits out each request's gap, then holds it until accepted.
  always @(posedge clk_i) begin
    logic next_valid;
    next_valid = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_list_request(cur_req.op, cur_req.value));
        n_pred     = n_pred + 1;
        next_valid = 1'b0;
        req_loaded = 1'b0;
      end
      if (!next_valid) begin
        if (!req_loaded && pending_reqs.size() > 0) begin
          cur_req    = pending_reqs.pop_front();
          req_loaded = 1'b1;
          gap_left   = cur_req.gap;
        end
        if (req_loaded) begin
          if (gap_left > 0) begin
            gap_left = gap_left - 1;
          end else if (!cur_req.drain || n_done == n_pred) begin
            next_valid = 1'b1;
            s_axis_tdata <= cur_req.value;
            s_axis_tuser <= cur_req.op;
          end
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Result monitor: checks each result and stalls a random number of cycles
  // after it, except in calm windows.
  always @(posedge clk_i) begin
    llf_res_t want;
    llf_res_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = status_e'(m_axis_tuser);
        got.value_out = m_axis_tdata[VALUE_W-1:0];
        got.queued    = m_axis_tdata[VALUE_W +: COUNT_W];
        got.free_len  = m_axis_tdata[VALUE_W + COUNT_W +: COUNT_W];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d value %h",
                   $time, m_axis_tuser, m_axis_tdata);
          err_count = err_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, m_axis_tuser);
            err_count = err_count + 1;
          end
          if (got.value_out !== want.value_out) begin
            $display("%0t: value_out mismatch, expected %h, actual %h",
                     $time, want.value_out, got.value_out);
            err_count = err_count + 1;
          end
          if (got.queued !== want.queued) begin
            $display("%0t: queued mismatch, expected %0d, actual %0d",
                     $time, want.queued, got.queued);
            err_count = err_count + 1;
          end
          if (got.free_len !== want.free_len) begin
            $display("%0t: free_length mismatch, expected %0d, actual %0d",
                     $time, want.free_len, got.free_len);
            err_count = err_count + 1;
          end
          n_done <= n_done + 1;
        end
        stall_left = ((cycle_count / 400) % 5 == 0) ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int   n_random;
    int   phase_len;
    int   enq_pct;
    bit   calm;
    mix_e mix;
    op_e  op;
    logic [VALUE_W-1:0] value;

    // Directed part: empty dequeue, value extremes, filling the pool to full.
    add_req(OP_DEQ, $urandom | 32'h1, 0, 1'b0);
    add_req(OP_ENQ, 32'h0000_0000, 0, 1'b0);
    add_req(OP_ENQ, 32'hFFFF_FFFF, 1, 1'b0);
    add_req(OP_DEQ, 32'hFFFF_FFFF, 0, 1'b0);
    add_req(OP_DEQ, 32'h0000_0000, 2, 1'b0);
    add_req(OP_DEQ, $urandom, 0, 1'b0);
    for (int i = 0; i < POOL - 1; i++) begin
      add_req(OP_ENQ, $urandom, $urandom_range(0, 2), 1'b0);
    end
    add_req(OP_ENQ, $urandom, 0, 1'b0);
    add_req(OP_DEQ, $urandom, 0, 1'b0);
    add_req(OP_DEQ, $urandom, 0, 1'b0);

    // Random part in phases of filling, draining and mixed traffic. The first
    // request holds off until every earlier result has come back.
    n_random = 0;
    while (n_random < RANDOM_REQS) begin
      phase_len = $urandom_range(5, 40);
      mix       = mix_e'($urandom_range(0, 2));
      calm      = ($urandom_range(0, 4) == 0);
      case (mix)
        MIX_FILL:  enq_pct = 80;
        MIX_DRAIN: enq_pct = 20;
        default:   enq_pct = 50;
      endcase
      for (int i = 0; i < phase_len; i++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        case ($urandom_range(0, 15))
          0:       value = '0;
          1:       value = '1;
          default: value = $urandom;
        endcase
        add_req(op, value, calm ? 0 : $urandom_range(0, 9),
                (n_random == 0) || (i == 0 && $urandom_range(0, 7) == 0));
        n_random = n_random + 1;
      end
    end
    n_total = pending_reqs.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_pred == n_total);
    wait (n_done == n_pred);
    repeat (SETTLE) @(posedge clk_i);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
